### rtl/core/linterp_pkg.sv
package linterp_pkg;

    typedef struct packed {
        logic in_range;
        logic falling;
    } linterp_ctl_t;

endpackage

### rtl/core/linear_interpolate_u8.sv
// Pipeline: a front stage, COORD_WIDTH divider cells and a back stage, each registered.
// Throughput: one transaction per cycle unless stalled; each of the COORD_WIDTH divider
// cells resolves one quotient bit and, when not stalled, passes its item to the next cell.
// Back-pressure: each cell holds its item while the next one is full and stalled.
// Reset: rst_n clears all valid flags asynchronously; payload registers are not reset.
module linear_interpolate_u8 #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // left_x, left_y, right_x, right_y, query_x
    input  logic [((5*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // interp_y
    output logic [((COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // in_range
    output logic [0:0]                             m_axis_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int OUT_W = ((COORD_WIDTH + 7) / 8) * 8;

    logic                       valid_bus [0:W];
    logic                       ready_bus [0:W];
    linterp_pkg::linterp_ctl_t  ctl_bus   [0:W];
    logic [W-1:0]               rem_bus   [0:W];
    logic [W-1:0]               lq_bus    [0:W];
    logic [W-1:0]               div_bus   [0:W];
    logic [W-1:0]               y1_bus    [0:W];
    logic [W-1:0]               interp_y;
    logic                       in_range;

    linterp_front #(
        .COORD_WIDTH (W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_axis_tvalid),
        .up_ready (s_axis_tready),
        .left_x   (s_axis_tdata[0*W +: W]),
        .left_y   (s_axis_tdata[1*W +: W]),
        .right_x  (s_axis_tdata[2*W +: W]),
        .right_y  (s_axis_tdata[3*W +: W]),
        .query_x  (s_axis_tdata[4*W +: W]),
        .dn_valid (valid_bus[0]),
        .dn_ready (ready_bus[0]),
        .dn_ctl   (ctl_bus[0]),
        .dn_rem   (rem_bus[0]),
        .dn_lq    (lq_bus[0]),
        .dn_div   (div_bus[0]),
        .dn_y1    (y1_bus[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_div
        linterp_div_cell #(
            .COORD_WIDTH (W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (valid_bus[i]),
            .up_ready (ready_bus[i]),
            .up_ctl   (ctl_bus[i]),
            .up_rem   (rem_bus[i]),
            .up_lq    (lq_bus[i]),
            .up_div   (div_bus[i]),
            .up_y1    (y1_bus[i]),
            .dn_valid (valid_bus[i+1]),
            .dn_ready (ready_bus[i+1]),
            .dn_ctl   (ctl_bus[i+1]),
            .dn_rem   (rem_bus[i+1]),
            .dn_lq    (lq_bus[i+1]),
            .dn_div   (div_bus[i+1]),
            .dn_y1    (y1_bus[i+1])
        );
    end

    linterp_back #(
        .COORD_WIDTH (W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (valid_bus[W]),
        .up_ready (ready_bus[W]),
        .up_ctl   (ctl_bus[W]),
        .up_quot  (lq_bus[W]),
        .up_y1    (y1_bus[W]),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .interp_y (interp_y),
        .in_range (in_range)
    );

    assign m_axis_tdata    = OUT_W'(interp_y);
    assign m_axis_tuser[0] = in_range;

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> interp_y == '0)
        else $error("out-of-range result is not zero");

    a_ready_passes_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        valid_bus[W] && ctl_bus[W].in_range |-> rem_bus[W] < div_bus[W])
        else $error("final remainder not below divisor");

endmodule

### rtl/core/linterp_front.sv
module linterp_front #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  logic [COORD_WIDTH-1:0]     left_x,
    input  logic [COORD_WIDTH-1:0]     left_y,
    input  logic [COORD_WIDTH-1:0]     right_x,
    input  logic [COORD_WIDTH-1:0]     right_y,
    input  logic [COORD_WIDTH-1:0]     query_x,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output linterp_pkg::linterp_ctl_t  dn_ctl,
    output logic [COORD_WIDTH-1:0]     dn_rem,
    output logic [COORD_WIDTH-1:0]     dn_lq,
    output logic [COORD_WIDTH-1:0]     dn_div,
    output logic [COORD_WIDTH-1:0]     dn_y1
);

    localparam int W = COORD_WIDTH;

    logic                       valid_reg;
    logic                       valid_next;
    linterp_pkg::linterp_ctl_t  ctl_reg;
    linterp_pkg::linterp_ctl_t  ctl_next;
    logic [W-1:0]               rem_reg;
    logic [W-1:0]               lq_reg;
    logic [W-1:0]               div_reg;
    logic [W-1:0]               y1_reg;
    logic [W-1:0]               span;
    logic [W-1:0]               offset;
    logic [2*W-1:0]             product;
    logic                       load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        ctl_next.in_range = (query_x > left_x) && (query_x < right_x);
        ctl_next.falling  = left_y > right_y;
        span    = ctl_next.falling ? (left_y - right_y) : (right_y - left_y);
        offset  = ctl_next.in_range ? (query_x - left_x) : '0;
        product = (2*W)'(span) * (2*W)'(offset);
    end

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= ctl_next;
            rem_reg <= product[2*W-1:W];
            lq_reg  <= product[W-1:0];
            div_reg <= right_x - left_x;
            y1_reg  <= left_y;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_lq    = lq_reg;
    assign dn_div   = div_reg;
    assign dn_y1    = y1_reg;

endmodule

### rtl/core/linterp_div_cell.sv
module linterp_div_cell #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  linterp_pkg::linterp_ctl_t  up_ctl,
    input  logic [COORD_WIDTH-1:0]     up_rem,
    input  logic [COORD_WIDTH-1:0]     up_lq,
    input  logic [COORD_WIDTH-1:0]     up_div,
    input  logic [COORD_WIDTH-1:0]     up_y1,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output linterp_pkg::linterp_ctl_t  dn_ctl,
    output logic [COORD_WIDTH-1:0]     dn_rem,
    output logic [COORD_WIDTH-1:0]     dn_lq,
    output logic [COORD_WIDTH-1:0]     dn_div,
    output logic [COORD_WIDTH-1:0]     dn_y1
);

    localparam int W = COORD_WIDTH;

    logic                       valid_reg;
    logic                       valid_next;
    linterp_pkg::linterp_ctl_t  ctl_reg;
    logic [W-1:0]               rem_reg;
    logic [W-1:0]               rem_next;
    logic [W-1:0]               lq_reg;
    logic [W-1:0]               lq_next;
    logic [W-1:0]               div_reg;
    logic [W-1:0]               y1_reg;
    logic [W:0]                 trial;
    logic [W:0]                 diff;
    logic                       take;
    logic                       load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        trial    = {up_rem, up_lq[W-1]};
        diff     = trial - {1'b0, up_div};
        take     = trial >= {1'b0, up_div};
        rem_next = take ? diff[W-1:0] : trial[W-1:0];
        lq_next  = {up_lq[W-2:0], take};
    end

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= up_ctl;
            rem_reg <= rem_next;
            lq_reg  <= lq_next;
            div_reg <= up_div;
            y1_reg  <= up_y1;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_ctl   = ctl_reg;
    assign dn_rem   = rem_reg;
    assign dn_lq    = lq_reg;
    assign dn_div   = div_reg;
    assign dn_y1    = y1_reg;

endmodule

### rtl/core/linterp_back.sv
module linterp_back #(
    parameter int COORD_WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  linterp_pkg::linterp_ctl_t  up_ctl,
    input  logic [COORD_WIDTH-1:0]     up_quot,
    input  logic [COORD_WIDTH-1:0]     up_y1,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output logic [COORD_WIDTH-1:0]     interp_y,
    output logic                       in_range
);

    localparam int W = COORD_WIDTH;

    logic          valid_reg;
    logic          valid_next;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  y_next;
    logic          range_reg;
    logic          load;

    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        if (!up_ctl.in_range)
        begin
            y_next = '0;
        end
        else if (up_ctl.falling)
        begin
            y_next = up_y1 - up_quot;
        end
        else
        begin
            y_next = up_y1 + up_quot;
        end
    end

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            y_reg     <= y_next;
            range_reg <= up_ctl.in_range;
        end
    end

    assign dn_valid = valid_reg;
    assign interp_y = y_reg;
    assign in_range = range_reg;

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 8;
    localparam int DW        = ((5*CW+7)/8)*8;
    localparam int OW        = ((CW+7)/8)*8;
    localparam int LATENCY   = CW + 2;
    localparam int N_ITEMS   = 1150;
    localparam int HOLD_LEN  = 90;
    localparam int IDLE_MAX  = 2000;

    typedef struct {
        logic [DW-1:0] data;
        bit            drain;
    } pending_item_t;

    typedef struct {
        logic [CW-1:0] interp_y;
        logic          in_range;
    } interp_result_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [DW-1:0]  s_axis_tdata = '0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [OW-1:0]  m_axis_tdata;
    logic [0:0]     m_axis_tuser;

    pending_item_t  pending_q[$];
    interp_result_t expected_q[$];

    bit  item_taken = 0;
    int  n_sent = 0;
    int  n_results = 0;
    int  n_inside = 0;
    int  n_outside = 0;
    int  n_falling = 0;
    int  n_errors = 0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  rx_cycle = 0;
    int  idle_cycles = 0;
    int  max_in_stall = 0;
    int  in_stall = 0;

    linear_interpolate_u8 #(
        .COORD_WIDTH(CW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic interp_result_t calc_interp(logic [DW-1:0] d);
        logic [CW-1:0]   x1;
        logic [CW-1:0]   y1;
        logic [CW-1:0]   x2;
        logic [CW-1:0]   y2;
        logic [CW-1:0]   xq;
        logic [CW-1:0]   span;
        logic [CW-1:0]   offset;
        logic [CW-1:0]   width;
        logic [2*CW-1:0] prod;
        logic [2*CW-1:0] quot;
        logic            falling;
        interp_result_t  r;
        x1 = d[0*CW +: CW];
        y1 = d[1*CW +: CW];
        x2 = d[2*CW +: CW];
        y2 = d[3*CW +: CW];
        xq = d[4*CW +: CW];
        r.interp_y = '0;
        r.in_range = 1'b0;
        if (xq > x1 && xq < x2)
        begin
            falling = (y1 > y2);
            span    = falling ? (y1 - y2) : (y2 - y1);
            offset  = xq - x1;
            width   = x2 - x1;
            prod    = (2*CW)'(span) * (2*CW)'(offset);
            quot    = prod / (2*CW)'(width);
            r.interp_y = falling ? (y1 - quot[CW-1:0]) : (y1 + quot[CW-1:0]);
            r.in_range = 1'b1;
        end
        return r;
    endfunction

    task automatic add_item(int x1, int y1, int x2, int y2, int xq, bit drain);
        pending_item_t p;
        p.data = '0;
        p.data[0*CW +: CW] = x1[CW-1:0];
        p.data[1*CW +: CW] = y1[CW-1:0];
        p.data[2*CW +: CW] = x2[CW-1:0];
        p.data[3*CW +: CW] = y2[CW-1:0];
        p.data[4*CW +: CW] = xq[CW-1:0];
        p.drain = drain;
        pending_q.push_back(p);
    endtask

    task automatic add_random_item(bit drain);
        int x1;
        int x2;
        int xq;
        int y1;
        int y2;
        int kind;
        kind = $urandom_range(0, 99);
        y1 = $urandom_range(0, 255);
        y2 = $urandom_range(0, 255);
        if (kind < 80)
        begin
            x1 = $urandom_range(0, 253);
            if (kind < 10)
                x2 = x1 + 2;
            else
                x2 = $urandom_range(x1 + 2, 255);
            xq = $urandom_range(x1 + 1, x2 - 1);
            if (kind >= 70)
                y2 = y1;
            else if (kind >= 60)
            begin
                y1 = ($urandom_range(0, 1) != 0) ? 255 : 0;
                y2 = 255 - y1;
            end
        end
        else
        begin
            x1 = $urandom_range(0, 255);
            x2 = $urandom_range(0, 255);
            xq = (kind < 88) ? (($urandom_range(0, 1) != 0) ? x1 : x2) : $urandom_range(0, 255);
        end
        add_item(x1, y1, x2, y2, xq, drain);
    endtask

    initial
    begin
        int n_directed;
        add_item(  0,   0,   0,   0,   0, 0);
        add_item(255, 255, 255, 255, 255, 0);
        add_item( 10,  20,  50, 200,  10, 0);
        add_item( 10,  20,  50, 200,  50, 0);
        add_item(200,  30, 100,  90, 150, 0);
        add_item( 77,  11,  77, 222,  77, 0);
        add_item(  0, 123, 255, 123, 128, 0);
        add_item(  0,   0, 255, 255, 254, 0);
        add_item(  0, 255, 255,   0,   1, 0);
        add_item(  0,   0,   2, 255,   1, 0);
        add_item(  3, 100,  10,   0,   5, 0);
        add_item(  3,   0,  10, 100,   9, 0);
        add_item(253,   0, 255, 255, 254, 0);
        add_item(  1, 255, 200, 254, 199, 0);
        add_item(  0,  50, 100,  60,   0, 0);
        add_item(100,  50, 255,  60, 255, 0);
        add_item(8'h55, 8'haa, 8'haa, 8'h55, 8'h80, 0);
        add_item(8'h2a, 8'h55, 8'hd5, 8'haa, 8'h7f, 0);
        add_item(128, 255, 127, 0, 128, 0);
        n_directed = pending_q.size();
        for (int i = n_directed; i < N_ITEMS; i++)
            add_random_item(i == n_directed || (i % 300) == 0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_q.size() == 0 && !s_axis_tvalid);
        wait (expected_q.size() == 0);
        repeat (4*LATENCY) @(posedge clk);

        $display("Sent %0d items; checked %0d results (%0d inside, %0d outside, %0d falling).",
                 n_sent, n_results, n_inside, n_outside, n_falling);
        $display("Longest input stall under output back-pressure: %0d cycles.", max_in_stall);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // sender: bursts with random gaps; optional drain before an item
    always @(negedge clk)
    begin
        logic          nxt_valid;
        logic [DW-1:0] nxt_data;
        nxt_valid = s_axis_tvalid;
        nxt_data  = s_axis_tdata;
        if (item_taken)
        begin
            void'(pending_q.pop_front());
            item_taken = 0;
            n_sent++;
            nxt_valid = 1'b0;
        end
        if (rst_n && !nxt_valid)
        begin
            if (pending_q.size() == 0)
                nxt_valid = 1'b0;
            else if (gap_left > 0 && hold_left == 0)
                gap_left--;
            else if (pending_q[0].drain && expected_q.size() != 0)
                nxt_valid = 1'b0;
            else
            begin
                nxt_valid = 1'b1;
                nxt_data  = pending_q[0].data;
                pending_q[0].drain = 0;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tdata  <= nxt_data;
    end

    // receiver: stall pattern rotates through four ready modes; one long hold
    always @(negedge clk)
    begin
        logic nxt_ready;
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            nxt_ready = 1'b0;
        end
        else if (!hold_done && n_results >= 300)
        begin
            hold_done = 1;
            hold_left = HOLD_LEN;
            nxt_ready = 1'b0;
        end
        else
        begin
            case ((rx_cycle / 97) % 4)
                0: nxt_ready = 1'b1;
                1: nxt_ready = ($urandom_range(0, 1) != 0);
                2: nxt_ready = ($urandom_range(0, 3) != 0);
                default: nxt_ready = ($urandom_range(0, 7) == 0);
            endcase
        end
        m_axis_tready <= nxt_ready;
    end

    always @(posedge clk)
    begin
        interp_result_t exp_r;
        bit accepted;
        accepted = 0;
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_q.push_back(calc_interp(s_axis_tdata));
            item_taken = 1;
            accepted = 1;
        end
        if (s_axis_tvalid && !s_axis_tready && m_axis_tvalid && !m_axis_tready)
            in_stall++;
        else
            in_stall = 0;
        if (in_stall > max_in_stall)
            max_in_stall = in_stall;
        if (m_axis_tvalid && m_axis_tready)
        begin
            accepted = 1;
            n_results++;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transaction: interp_y=%0d in_range=%0d",
                       m_axis_tdata[CW-1:0], m_axis_tuser[0]);
                n_errors++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (exp_r.in_range)
                    n_inside++;
                else
                    n_outside++;
                if (m_axis_tdata[CW-1:0] !== exp_r.interp_y)
                begin
                    $error("interp_y mismatch: expected %0d, actual %0d",
                           exp_r.interp_y, m_axis_tdata[CW-1:0]);
                    n_errors++;
                end
                if (m_axis_tuser[0] !== exp_r.in_range)
                begin
                    $error("in_range mismatch: expected %0d, actual %0d",
                           exp_r.in_range, m_axis_tuser[0]);
                    n_errors++;
                end
            end
        end
        if (rst_n && !accepted)
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("Timeout: no transaction for %0d cycles", IDLE_MAX);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            if (s_axis_tdata[1*CW +: CW] > s_axis_tdata[3*CW +: CW]
                && s_axis_tdata[4*CW +: CW] > s_axis_tdata[0*CW +: CW]
                && s_axis_tdata[4*CW +: CW] < s_axis_tdata[2*CW +: CW])
                n_falling++;
        end
    end

endmodule
